/* rtl/core/idt_pkg.sv */
// Shared types and constants for the indent/dedent tokenizer core.
// No dependencies.

package idt_pkg;

	typedef enum logic [1:0] {
		TOK_INDENT     = 2'd0,
		TOK_DEDENT     = 2'd1,
		TOK_NEWLINE    = 2'd2,
		TOK_WS_NEWLINE = 2'd3
	} token_kind_t;

	localparam int unsigned QUEUE_BITS  = 6;
	localparam int unsigned QUEUE_MAX   = 63;
	localparam int unsigned MAX_RESULTS = 64;
	localparam int unsigned TAB_BITS    = 5;
	localparam logic [TAB_BITS-1:0] TAB_RESET = 5'd4;

	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_END  = 1'b1;

	// One request's worth of tokens: leading DEDENTs, optional token, trailing DEDENTs.
	typedef struct packed {
		logic [QUEUE_BITS-1:0] lead;
		logic                  tok;
		token_kind_t           kind;
		logic [QUEUE_BITS-1:0] trail;
	} emit_req_t;

endpackage

/* rtl/core/idt_emit.sv */
// Token emitter: serializes one emit request into the output stream register.
// Depends on idt_pkg.

module idt_emit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  idt_pkg::emit_req_t req,
	output logic               ready,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [7:0]         m_tdata,   // [1:0] token_kind, [7:2] zero
	output logic               m_tlast    // run_last
);
	import idt_pkg::*;

	logic [QUEUE_BITS-1:0] lead_q, trail_q, lead_n, trail_n;
	logic                  tok_q, tok_n;
	token_kind_t           kind_q, cur_kind;
	logic                  rem, adv, last_now;

	assign rem = (lead_q != '0) || tok_q || (trail_q != '0);
	assign adv = rem && (!m_tvalid || m_tready);

	always_comb begin
		lead_n   = lead_q;
		tok_n    = tok_q;
		trail_n  = trail_q;
		cur_kind = TOK_DEDENT;
		if (lead_q != '0) begin
			lead_n = lead_q - 1'b1;
		end else if (tok_q) begin
			tok_n    = 1'b0;
			cur_kind = kind_q;
		end else if (trail_q != '0) begin
			trail_n = trail_q - 1'b1;
		end
	end

	assign last_now = (lead_n == '0) && !tok_n && (trail_n == '0);
	assign ready    = !rem || (adv && last_now);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q   <= '0;
			tok_q    <= 1'b0;
			trail_q  <= '0;
			kind_q   <= TOK_INDENT;
			m_tvalid <= 1'b0;
			m_tdata  <= '0;
			m_tlast  <= 1'b0;
		end else begin
			if (load) begin
				lead_q  <= req.lead;
				tok_q   <= req.tok;
				kind_q  <= req.kind;
				trail_q <= req.trail;
			end else if (adv) begin
				lead_q  <= lead_n;
				tok_q   <= tok_n;
				trail_q <= trail_n;
			end
			if (adv) begin
				m_tvalid <= 1'b1;
				m_tdata  <= {6'd0, cur_kind};
				m_tlast  <= last_now;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/indent_dedent_tokenizer_core.sv */
// Top level of the offside-rule layout tokenizer: line state, level stack RAM,
// pop sequencer. Depends on idt_pkg and idt_emit.
//
// Usage:
//   s_* carries one request per source byte (tuser = 1 marks end of input)
//   together with the parser's token-accept flags. m_* returns layout tokens,
//   one per beat; tlast marks the last token caused by a request. Requests
//   that cause no token produce no beat. cfg_we/cfg_wdata set tab_width and
//   are to be written only while idle; the block itself does not enforce it.
// Flow: a request that needs no pop run is taken as soon as the emitter is
//   free; no new request is taken while the emitter drains. A shallower line
//   start or an end of input runs the pop sequencer: per popped level a level
//   stack RAM read, then a compare. Pops stop once the level is not deeper,
//   at the base level, or when the DEDENT queue holds 63.
// Path: tokens pass through the emitter's request registers and then its
//   output register; a pop run first steps through POP, POP_WAIT and FIN.
// Reset (arst_n low): one open level at indent 0, empty DEDENT queue,
//   tab_width 4; no RAM clearing pass is needed.
// Stall: the output register holds while m_tready is low; the next request
//   is still taken once the emitter has handed off its last token.

module indent_dedent_tokenizer_core #(
	parameter int unsigned STACK_DEPTH = 32,
	parameter int unsigned INDENT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,  // tab_width
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [7:0] text_byte, [8] indent_ok, [9] dedent_ok,
	                                // [10] newline_ok, [11] ws_newline_ok, [15:12] zero
	input  logic        s_tuser,    // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [1:0] token_kind, [7:2] zero
	output logic        m_tlast     // run_last
);
	import idt_pkg::*;

	localparam int unsigned CNT_W  = $clog2(STACK_DEPTH + 1);
	localparam int unsigned ADDR_W = $clog2(STACK_DEPTH);
	localparam logic [INDENT_BITS-1:0] INDENT_MAX = {INDENT_BITS{1'b1}};

	typedef enum logic [1:0] {
		LM_CONTENT = 2'd0,
		LM_MEASURE = 2'd1,
		LM_COMMENT = 2'd2,
		LM_SPARE   = 2'd3
	} line_mode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_POP_WAIT,
		ST_FIN
	} state_t;

	state_t                 state_q;
	line_mode_t             mode_q;
	logic [INDENT_BITS-1:0] indent_q, cmp_q, top_lvl_q;
	logic [CNT_W-1:0]       count_q;
	logic [QUEUE_BITS-1:0]  queued_q;
	logic                   saw_cr_q, end_done_q, pop_all_q, dedent_q;
	logic [TAB_BITS-1:0]    tab_q;
	emit_req_t              req_q;

	logic [INDENT_BITS-1:0] stack_mem [STACK_DEPTH];
	logic [INDENT_BITS-1:0] rd_data;
	logic                   rd_en;
	logic [ADDR_W-1:0]      rd_addr;

	logic                   emit_ready, emit_load;
	emit_req_t              emit_req;

	logic [7:0]             b;
	logic                   in_ind_ok, in_ded_ok, in_nl_ok, in_ws_ok, accept;
	logic                   is_brk;
	logic [INDENT_BITS:0]   sum_sp, sum_tab;
	logic [INDENT_BITS-1:0] sat_sp, sat_tab;
	logic                   pop_cond;
	logic [CNT_W-1:0]       count_dec;
	logic [6:0]             avail;
	logic [QUEUE_BITS-1:0]  trail_n;

	assign b         = s_tdata[7:0];
	assign in_ind_ok = s_tdata[8];
	assign in_ded_ok = s_tdata[9];
	assign in_nl_ok  = s_tdata[10];
	assign in_ws_ok  = s_tdata[11];
	assign is_brk    = (b == CH_CR) || (b == CH_LF);

	assign sum_sp  = {1'b0, indent_q} + (INDENT_BITS + 1)'(1);
	assign sum_tab = {1'b0, indent_q} + (INDENT_BITS + 1)'(tab_q);
	assign sat_sp  = sum_sp[INDENT_BITS] ? INDENT_MAX : sum_sp[INDENT_BITS-1:0];
	assign sat_tab = sum_tab[INDENT_BITS] ? INDENT_MAX : sum_tab[INDENT_BITS-1:0];

	assign s_tready = (state_q == ST_IDLE) && emit_ready;
	assign accept   = s_tvalid && s_tready;

	assign count_dec = count_q - 1'b1;
	assign pop_cond  = (count_q > CNT_W'(1)) && (queued_q != QUEUE_BITS'(QUEUE_MAX))
	                   && (pop_all_q || (top_lvl_q > cmp_q));
	assign rd_en     = (state_q == ST_POP) && pop_cond;
	assign rd_addr   = ADDR_W'(count_q - CNT_W'(2));

	assign avail   = 7'(MAX_RESULTS) - {1'b0, req_q.lead} - {6'd0, req_q.tok};
	assign trail_n = !dedent_q ? '0 :
	                 ({1'b0, queued_q} < avail) ? queued_q : avail[QUEUE_BITS-1:0];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= stack_mem[rd_addr];
		end
	end

	// Push path: written only from IDLE, read only later in POP states.
	logic                   push;
	logic [INDENT_BITS-1:0] push_val;
	logic [ADDR_W-1:0]      push_addr;
	assign push_addr = count_q[ADDR_W-1:0];

	always_ff @(posedge clk) begin
		if (push) begin
			stack_mem[push_addr] <= push_val;
		end
	end

	// Decode of one request in IDLE.
	logic                   n_tok, n_pops, n_pop_all;
	token_kind_t            n_kind;
	line_mode_t             n_mode;
	logic [INDENT_BITS-1:0] n_indent;
	logic                   n_saw_cr, n_end_done;

	always_comb begin
		n_tok      = 1'b0;
		n_kind     = TOK_NEWLINE;
		n_pops     = 1'b0;
		n_pop_all  = 1'b0;
		n_mode     = mode_q;
		n_indent   = indent_q;
		n_saw_cr   = saw_cr_q;
		n_end_done = end_done_q;
		push       = 1'b0;
		push_val   = indent_q;
		if (s_tuser == CMD_END) begin
			if (!end_done_q && in_nl_ok) begin
				n_end_done = 1'b1;
				n_pops     = 1'b1;
				n_pop_all  = 1'b1;
				n_tok      = 1'b1;
				n_kind     = TOK_NEWLINE;
			end
		end else if (saw_cr_q && (b == CH_LF)) begin
			n_saw_cr = 1'b0;
		end else begin
			n_saw_cr = (b == CH_CR);
			case (mode_q)
				LM_MEASURE: begin
					if (is_brk) begin
						n_indent = '0;
					end else if (b == CH_SPACE) begin
						n_indent = sat_sp;
					end else if (b == CH_TAB) begin
						n_indent = sat_tab;
					end else if (b == CH_HASH) begin
						n_mode   = LM_COMMENT;
						n_indent = '0;
					end else begin
						if (indent_q > top_lvl_q) begin
							if ((count_q < CNT_W'(STACK_DEPTH)) && in_ind_ok) begin
								push   = accept;
								n_tok  = 1'b1;
								n_kind = TOK_INDENT;
							end
						end else if (indent_q < top_lvl_q) begin
							n_pops = 1'b1;
						end
						n_mode   = LM_CONTENT;
						n_indent = '0;
					end
				end
				LM_COMMENT: begin
					if (is_brk) begin
						n_mode   = LM_MEASURE;
						n_indent = '0;
					end
				end
				default: begin
					if (is_brk) begin
						if (in_nl_ok) begin
							n_tok    = 1'b1;
							n_kind   = TOK_NEWLINE;
							n_mode   = LM_MEASURE;
							n_indent = '0;
						end else if (in_ws_ok) begin
							n_tok  = 1'b1;
							n_kind = TOK_WS_NEWLINE;
						end
					end
				end
			endcase
		end
	end

	always_comb begin
		emit_load = 1'b0;
		emit_req  = req_q;
		if (state_q == ST_IDLE) begin
			emit_req.lead  = in_ded_ok ? queued_q : '0;
			emit_req.tok   = n_tok;
			emit_req.kind  = n_kind;
			emit_req.trail = '0;
			emit_load      = accept && !n_pops && (n_tok || (in_ded_ok && (queued_q != '0)));
		end else if (state_q == ST_FIN) begin
			emit_req.trail = trail_n;
			emit_load      = emit_ready &&
			                 ((req_q.lead != '0) || req_q.tok || (trail_n != '0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= LM_CONTENT;
			indent_q   <= '0;
			top_lvl_q  <= '0;
			count_q    <= CNT_W'(1);
			queued_q   <= '0;
			saw_cr_q   <= 1'b0;
			end_done_q <= 1'b0;
			pop_all_q  <= 1'b0;
			dedent_q   <= 1'b0;
			tab_q      <= TAB_RESET;
			cmp_q      <= '0;
			req_q      <= '0;
		end else begin
			if (cfg_we) begin
				tab_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q     <= n_mode;
						indent_q   <= n_indent;
						saw_cr_q   <= n_saw_cr;
						end_done_q <= n_end_done;
						dedent_q   <= in_ded_ok;
						pop_all_q  <= n_pop_all;
						cmp_q      <= indent_q;
						req_q      <= emit_req;
						if (in_ded_ok) begin
							queued_q <= '0;
						end
						if (push) begin
							count_q   <= count_q + 1'b1;
							top_lvl_q <= indent_q;
						end
						if (n_pops) begin
							state_q <= ST_POP;
						end
					end
				end
				ST_POP: begin
					if (pop_cond) begin
						count_q  <= count_dec;
						queued_q <= queued_q + 1'b1;
						state_q  <= ST_POP_WAIT;
					end else begin
						state_q <= ST_FIN;
					end
				end
				ST_POP_WAIT: begin
					top_lvl_q <= (count_q == CNT_W'(1)) ? '0 : rd_data;
					state_q   <= ST_POP;
				end
				ST_FIN: begin
					if (emit_ready) begin
						queued_q <= queued_q - trail_n;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	idt_emit u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (emit_load),
		.req      (emit_req),
		.ready    (emit_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule
